// ===== design/hbd_pkg.sv =====
// Shared types, widths and codes for the Huffman tree bit decoder.
package hbd_pkg;

	localparam int IDX_W          = 9;
	localparam int SYM_W          = 8;
	localparam int BYTE_W         = 8;
	localparam int CNT_W          = 32;
	localparam int BITS_W         = $clog2(BYTE_W + 1);
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 32;
	localparam int S_TDATA_W      = 48;
	localparam int M_TDATA_W      = 8;
	localparam int TREE_NODES_DEF = 511;

	localparam logic [CFG_IDX_W-1:0] REG_ROOT_NODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SYMBOLS = 2'd1;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_DATA = 1'b1;

	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic             leaf;
		logic [IDX_W-1:0] right;
		logic [IDX_W-1:0] left;
	} node_t;

	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic             finished;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_WALK,
		ST_CHECK,
		ST_FLUSH
	} state_t;

endpackage

// ===== design/huffman_tree_bit_decoder.sv =====
// Top level of the Huffman tree bit decoder: bit-serial tree walk over a node table.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+-------------------------------------------
//  s_      | in  | s_tvalid / s_tready       | s_tuser: req_type; s_tdata: node fields, byte
//  m_      | out | m_tvalid / m_tready       | m_tdata: symbol; m_tlast: last; m_tuser: finished
//  cfg_    | in  | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// A node load is written to the table as it is accepted. A data byte is accepted, the current
// node is fetched, and each bit reads the chosen child from the single registered read port of
// the node RAM and then checks it; the root is refetched after each symbol that does not end the
// byte, and a closing state flushes the last symbol. A byte that reaches the count ends sooner;
// one that arrives after it is dropped. The byte's bits shift out of a register one per step.
// Reset clears the walk, root, total, count and valid flags; the data registers and node table are not.
// A full output register with a symbol already pending stalls the walk in place at a leaf.
module huffman_tree_bit_decoder #(
	parameter int TREE_NODES = hbd_pkg::TREE_NODES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [8:0] node_index, [17:9] left_child, [26:18] right_child, [27] leaf_flag,
	// [35:28] leaf_symbol, [43:36] data_byte, [47:44] zero
	input  logic [hbd_pkg::S_TDATA_W-1:0]    s_tdata,
	// [0] req_type
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [7:0] symbol
	output logic [hbd_pkg::M_TDATA_W-1:0]    m_tdata,
	output logic                             m_tlast,
	// [0] finished
	output logic                             m_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [hbd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hbd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import hbd_pkg::*;

	localparam int               NODE_AW   = $clog2(TREE_NODES);
	localparam logic [IDX_W:0]   NODES_LIM = (IDX_W + 1)'(TREE_NODES);

	state_t state_q, state_nxt;

	logic [IDX_W-1:0]  root_q;
	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  cur_q;
	logic [IDX_W-1:0]  next_q;
	logic [BYTE_W-1:0] byte_q;
	logic [BITS_W-1:0] bits_left_q;
	logic              rd_oor_q;
	logic              pend_vld_q;
	result_t           pend_q;
	logic              out_vld_q;
	logic [SYM_W-1:0]  out_sym_q;
	logic              out_last_q;
	logic              out_fin_q;

	logic [IDX_W-1:0]  f_node_index;
	node_t             f_node;
	logic [BYTE_W-1:0] f_data_byte;

	logic              s_accept;
	logic              wr_en;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              rd_in_range;
	node_t             rd_data;
	node_t             ent;
	logic [IDX_W-1:0]  next_c;
	logic              out_free;
	logic              out_load;
	logic [CNT_W-1:0]  cnt_inc;
	logic [CNT_W-1:0]  cnt_after;
	logic              stall;

	assign f_node_index = s_tdata[8:0];
	assign f_node.left  = s_tdata[17:9];
	assign f_node.right = s_tdata[26:18];
	assign f_node.leaf  = s_tdata[27];
	assign f_node.sym   = s_tdata[35:28];
	assign f_data_byte  = s_tdata[43:36];

	assign s_accept  = s_tvalid && s_tready;
	assign wr_en     = s_accept && (s_tuser == REQ_LOAD) &&
	                   ({1'b0, f_node_index} < NODES_LIM);
	assign cfg_ready = 1'b1;

	// An index past the table reads as an all-zero node.
	assign ent       = rd_oor_q ? '0 : rd_data;
	assign next_c    = byte_q[BYTE_W-1] ? ent.right : ent.left;
	assign out_free  = !out_vld_q || m_tready;
	assign cnt_inc   = count_q + 1'b1;
	assign cnt_after = ent.leaf ? cnt_inc : count_q;
	assign stall     = ent.leaf && pend_vld_q && !out_free;
	assign rd_in_range = ({1'b0, rd_addr} < NODES_LIM);

	// Move the pending symbol out when a newer one arrives or the byte closes.
	assign out_load  = ((state_q == ST_CHECK) && !stall && ent.leaf && pend_vld_q) ||
	                   ((state_q == ST_FLUSH) && pend_vld_q && out_free);

	hbd_node_ram #(
		.TREE_NODES (TREE_NODES),
		.NODE_AW    (NODE_AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (f_node_index[NODE_AW-1:0]),
		.wr_data (f_node),
		.rd_en   (rd_en),
		.rd_addr (rd_addr[NODE_AW-1:0]),
		.rd_data (rd_data)
	);

	always_comb begin
		state_nxt = state_q;
		s_tready  = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = cur_q;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_accept && (s_tuser == REQ_DATA) && (count_q < total_q)) begin
					state_nxt = ST_FETCH;
				end
			end
			ST_FETCH: begin
				rd_en     = 1'b1;
				rd_addr   = cur_q;
				state_nxt = ST_WALK;
			end
			ST_WALK: begin
				rd_en     = 1'b1;
				rd_addr   = next_c;
				state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				if (!stall) begin
					if ((bits_left_q == '0) || (cnt_after >= total_q)) begin
						state_nxt = ST_FLUSH;
					end else if (ent.leaf) begin
						state_nxt = ST_FETCH;
					end else begin
						state_nxt = ST_WALK;
					end
				end
			end
			ST_FLUSH: begin
				if (!pend_vld_q || out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q     <= '0;
			total_q    <= '0;
			count_q    <= '0;
			cur_q      <= '0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ROOT_NODE: begin
						root_q <= cfg_data[IDX_W-1:0];
						cur_q  <= cfg_data[IDX_W-1:0];
					end
					REG_TOTAL_SYMBOLS: begin
						total_q <= cfg_data[CNT_W-1:0];
						count_q <= '0;
					end
					default: begin
					end
				endcase
			end

			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				ST_CHECK: begin
					if (!stall) begin
						cur_q <= ent.leaf ? root_q : next_q;
						if (ent.leaf) begin
							count_q    <= cnt_inc;
							pend_vld_q <= 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					if (pend_vld_q && out_free) begin
						pend_vld_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_oor_q <= !rd_in_range;
		end
		case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					byte_q      <= f_data_byte;
					bits_left_q <= BITS_W'(BYTE_W);
				end
			end
			ST_WALK: begin
				next_q      <= next_c;
				byte_q      <= {byte_q[BYTE_W-2:0], 1'b0};
				bits_left_q <= bits_left_q - 1'b1;
			end
			ST_CHECK: begin
				if (!stall && ent.leaf) begin
					pend_q.sym      <= ent.sym;
					pend_q.finished <= (cnt_inc == total_q);
					// The older symbol is not the last of the byte.
					if (pend_vld_q) begin
						out_sym_q  <= pend_q.sym;
						out_fin_q  <= pend_q.finished;
						out_last_q <= 1'b0;
					end
				end
			end
			ST_FLUSH: begin
				if (pend_vld_q && out_free) begin
					out_sym_q  <= pend_q.sym;
					out_fin_q  <= pend_q.finished;
					out_last_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_sym_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_fin_q;

endmodule

// ===== design/hbd_node_ram.sv =====
// Node table: one write port, one registered read port.
module hbd_node_ram #(
	parameter int TREE_NODES = hbd_pkg::TREE_NODES_DEF,
	parameter int NODE_AW    = $clog2(TREE_NODES)
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [NODE_AW-1:0]   wr_addr,
	input  hbd_pkg::node_t       wr_data,
	input  logic                 rd_en,
	input  logic [NODE_AW-1:0]   rd_addr,
	output hbd_pkg::node_t       rd_data
);
	import hbd_pkg::*;

	node_t mem_q [TREE_NODES];
	node_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
